// ===== rtl/prcc_pkg.sv =====
// Shared types and constants for the palette RAM color-cycling block.
// Used by the top level, the palette RAM and the remainder unit.
// No dependencies.
package prcc_pkg;

  // Default palette depth.
  localparam int PALETTE_ENTRIES_DEF = 256;

  // Fixed field widths.
  localparam int COLOR_W = 15;
  localparam int IDX_W   = 8;
  localparam int CNT_W   = 16;
  localparam int SPD_W   = 8;
  localparam int RCNT_W  = 9;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [1:0] REG_RANGE_START    = 2'd0;
  localparam logic [1:0] REG_RANGE_COUNT    = 2'd1;
  localparam logic [1:0] REG_ROTATE_SPEED   = 2'd2;
  localparam logic [1:0] REG_ROTATE_PALETTE = 2'd3;

endpackage

// ===== rtl/prcc_pal_ram.sv =====
// One palette memory with a registered read port and per-entry valid bits.
// Entries never written read as zero. Depends on prcc_pkg.
module prcc_pal_ram #(
  parameter int ENTRIES = prcc_pkg::PALETTE_ENTRIES_DEF,
  parameter int AW      = $clog2(ENTRIES)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         we,
  input  logic                         re,
  input  logic [AW-1:0]                addr,
  input  logic [prcc_pkg::COLOR_W-1:0] wdata,
  output logic [prcc_pkg::COLOR_W-1:0] rdata
);
  import prcc_pkg::*;

  logic [COLOR_W-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  logic [COLOR_W-1:0] rd_data_r;
  logic               rd_vld_r;

  // Storage array: one write and one read per cycle, both on the same address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[addr];
    end
  end

  // Valid bits clear at reset so the whole palette reads as zero at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[addr] <= 1'b1;
      end
      if (re) begin
        rd_vld_r <= vld_r[addr];
      end
    end
  end

  assign rdata = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== rtl/prcc_mod_unit.sv =====
// Iterative remainder unit: tick counter modulo rotation period, one bit a cycle.
// Restoring shift-and-subtract over the counter bits. Depends on prcc_pkg.
module prcc_mod_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [prcc_pkg::CNT_W-1:0] dividend,
  input  logic [prcc_pkg::SPD_W-1:0] divisor,
  output logic                       done,
  output logic                       rem_zero
);
  import prcc_pkg::*;

  localparam int STEP_W = $clog2(CNT_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  dvd_r;
  logic [SPD_W-1:0]  dsr_r;
  logic [SPD_W-1:0]  rem_r;
  logic [SPD_W:0]    trial;
  logic [SPD_W:0]    diff;
  logic [SPD_W-1:0]  rem_nxt;

  // Shared compare and subtract: bring in the next dividend bit.
  always_comb begin
    trial = {rem_r, dvd_r[CNT_W-1]};
    diff  = trial - {1'b0, dsr_r};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = diff[SPD_W-1:0];
    end else begin
      rem_nxt = trial[SPD_W-1:0];
    end
  end

  // Step sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(CNT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[CNT_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign rem_zero = (rem_r == '0);

endmodule

// ===== rtl/palette_ram_color_cycling.sv =====
// Top level of the palette RAM color-cycling block: stream ports, APB-style
// configuration, sequencer. Depends on prcc_pkg, prcc_pal_ram, prcc_mod_unit.
//
// A write, a read or an unused item passes from S_IDLE through S_DONE to the
// result register. A frame tick first runs the remainder unit, which works one
// counter bit per cycle, and when it rotates a range, each moved entry needs a
// read and a write on the single palette port. The next item is taken while a
// finished result still waits on the output. Both palettes read as zero right
// after reset; there is no clearing pass.
module palette_ram_color_cycling #(
  parameter int PALETTE_ENTRIES = prcc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic [2:0]  in_tuser,   // op[1:0], palette_sel[2]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // read_colour[14:0], zero[15]
  output logic [0:0]  out_tuser,  // rotated[0]
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import prcc_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DONE     = 8'b0000_0010,
    S_MOD      = 8'b0000_0100,
    S_ROT_KEEP = 8'b0000_1000,
    S_ROT_HOLD = 8'b0001_0000,
    S_ROT_RD   = 8'b0010_0000,
    S_ROT_WR   = 8'b0100_0000,
    S_ROT_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [IDX_W-1:0]  range_start_r;
  logic [RCNT_W-1:0] range_count_r;
  logic [SPD_W-1:0]  rotate_speed_r;
  logic              rotate_palette_r;

  logic [CNT_W-1:0]   tick_counter_r;
  logic               mem_sel_r, mem_sel_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic               res_rot_r, res_rot_nxt;
  logic               up_r, up_nxt;
  logic               per_nz_r, per_nz_nxt;
  logic [AW-1:0]      dst_r, dst_nxt;
  logic [COLOR_W-1:0] keep_r, keep_nxt;

  logic               out_tvalid_r;
  logic [COLOR_W-1:0] out_colour_r;
  logic               out_rot_r;

  // Input fields.
  op_t              in_op;
  logic             in_sel;
  logic [IDX_W-1:0] in_idx;
  logic             in_xfer;
  logic             idx_ok;
  logic [COLOR_W-1:0] in_colour;

  // Palette port controls.
  logic [1:0]         mem_we, mem_re;
  logic [AW-1:0]      mem_addr;
  logic [COLOR_W-1:0] mem_wdata;
  logic [COLOR_W-1:0] bg_rdata, spr_rdata, rdata_sel;

  // Remainder unit.
  logic             mod_start, mod_done, mod_rem_zero;
  logic [SPD_W-1:0] period;
  logic             speed_down;

  // Range geometry.
  logic [IDX_W+1:0] last_raw, last_clip;
  logic             rng_ok;
  logic [AW-1:0]    first_a, last_a, end0_a, end1_a, dst_step;

  logic out_free;
  logic cfg_wr;

  assign in_op     = op_t'(in_tuser[1:0]);
  assign in_sel    = in_tuser[2];
  assign in_idx    = in_tdata[7:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign idx_ok    = ({1'b0, in_idx} < (IDX_W + 1)'(PALETTE_ENTRIES));
  assign out_free  = !out_tvalid_r || out_tready;

  // Pack 8-bit components into 5:5:5, red in the low bits.
  assign in_colour = {in_tdata[31:27], in_tdata[23:19], in_tdata[15:11]};

  // Configuration writes and reads.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r    <= '0;
      range_count_r    <= '0;
      rotate_speed_r   <= '0;
      rotate_palette_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_RANGE_START:    range_start_r    <= cfg_pwdata[IDX_W-1:0];
        REG_RANGE_COUNT:    range_count_r    <= cfg_pwdata[RCNT_W-1:0];
        REG_ROTATE_SPEED:   rotate_speed_r   <= cfg_pwdata[SPD_W-1:0];
        REG_ROTATE_PALETTE: rotate_palette_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_RANGE_START:    cfg_prdata = {24'd0, range_start_r};
      REG_RANGE_COUNT:    cfg_prdata = {23'd0, range_count_r};
      REG_ROTATE_SPEED:   cfg_prdata = {24'd0, rotate_speed_r};
      REG_ROTATE_PALETTE: cfg_prdata = {31'd0, rotate_palette_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // Rotation period: magnitude of the speed; the most negative speed gives 128.
  assign speed_down = rotate_speed_r[SPD_W-1];
  assign period     = speed_down ? (~rotate_speed_r + 1'b1) : rotate_speed_r;

  // Range bounds, clipped at the last palette entry.
  always_comb begin
    last_raw = {2'b00, range_start_r} + {1'b0, range_count_r} - 1'b1;
    if (last_raw > (IDX_W + 2)'(PALETTE_ENTRIES - 1)) begin
      last_clip = (IDX_W + 2)'(PALETTE_ENTRIES - 1);
    end else begin
      last_clip = last_raw;
    end
    rng_ok = ({1'b0, range_start_r} < (IDX_W + 1)'(PALETTE_ENTRIES)) &&
             (range_count_r >= RCNT_W'(2)) &&
             (last_clip > {2'b00, range_start_r});
  end

  assign first_a  = range_start_r[AW-1:0];
  assign last_a   = last_clip[AW-1:0];
  assign end0_a   = up_r ? last_a : first_a;
  assign end1_a   = up_r ? first_a : last_a;
  assign dst_step = up_r ? (dst_r - 1'b1) : (dst_r + 1'b1);

  assign rdata_sel = mem_sel_r ? spr_rdata : bg_rdata;
  assign mod_start = in_xfer && (in_op == OP_TICK);

  // Sequencer and palette port control.
  always_comb begin
    state_nxt   = state_r;
    mem_sel_nxt = mem_sel_r;
    rd_ok_nxt   = rd_ok_r;
    res_rot_nxt = res_rot_r;
    up_nxt      = up_r;
    per_nz_nxt  = per_nz_r;
    dst_nxt     = dst_r;
    keep_nxt    = keep_r;
    mem_we      = 2'b00;
    mem_re      = 2'b00;
    mem_addr    = dst_r;
    mem_wdata   = rdata_sel;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          rd_ok_nxt   = 1'b0;
          res_rot_nxt = 1'b0;
          mem_sel_nxt = in_sel;
          mem_addr    = in_idx[AW-1:0];
          mem_wdata   = in_colour;
          state_nxt   = S_DONE;
          case (in_op)
            OP_WRITE: begin
              if (idx_ok) begin
                mem_we[in_sel] = 1'b1;
              end
            end
            OP_READ: begin
              if (idx_ok) begin
                mem_re[in_sel] = 1'b1;
                rd_ok_nxt      = 1'b1;
              end
            end
            OP_TICK: begin
              mem_sel_nxt = rotate_palette_r;
              up_nxt      = !speed_down;
              per_nz_nxt  = (period != '0);
              state_nxt   = S_MOD;
            end
            default: ;
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          if (per_nz_r && mod_rem_zero && rng_ok) begin
            dst_nxt   = end0_a;
            state_nxt = S_ROT_KEEP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      // Read the entry that wraps around to the far end.
      S_ROT_KEEP: begin
        mem_re[mem_sel_r] = 1'b1;
        state_nxt         = S_ROT_HOLD;
      end
      S_ROT_HOLD: begin
        keep_nxt          = rdata_sel;
        mem_re[mem_sel_r] = 1'b1;
        mem_addr          = dst_step;
        state_nxt         = S_ROT_WR;
      end
      S_ROT_RD: begin
        mem_re[mem_sel_r] = 1'b1;
        mem_addr          = dst_step;
        state_nxt         = S_ROT_WR;
      end
      // Move the neighbor into place and step toward the far end.
      S_ROT_WR: begin
        mem_we[mem_sel_r] = 1'b1;
        dst_nxt           = dst_step;
        if (dst_step == end1_a) begin
          state_nxt = S_ROT_FIN;
        end else begin
          state_nxt = S_ROT_RD;
        end
      end
      S_ROT_FIN: begin
        mem_we[mem_sel_r] = 1'b1;
        mem_wdata         = keep_r;
        res_rot_nxt       = 1'b1;
        state_nxt         = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      tick_counter_r <= '0;
      out_tvalid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mod_start) begin
        tick_counter_r <= tick_counter_r + 1'b1;
      end
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Item context and the output register.
  always_ff @(posedge clk) begin
    mem_sel_r <= mem_sel_nxt;
    rd_ok_r   <= rd_ok_nxt;
    res_rot_r <= res_rot_nxt;
    up_r      <= up_nxt;
    per_nz_r  <= per_nz_nxt;
    dst_r     <= dst_nxt;
    keep_r    <= keep_nxt;
    if (state_r == S_DONE && out_free) begin
      out_colour_r <= rd_ok_r ? rdata_sel : '0;
      out_rot_r    <= res_rot_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_colour_r};
  assign out_tuser  = out_rot_r;

  // Background and sprite palettes.
  prcc_pal_ram #(
    .ENTRIES (PALETTE_ENTRIES),
    .AW      (AW)
  ) u_bg_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we[0]),
    .re    (mem_re[0]),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (bg_rdata)
  );

  prcc_pal_ram #(
    .ENTRIES (PALETTE_ENTRIES),
    .AW      (AW)
  ) u_spr_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we[1]),
    .re    (mem_re[1]),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (spr_rdata)
  );

  // Tick counter modulo the rotation period.
  prcc_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (tick_counter_r + 1'b1),
    .divisor  (period),
    .done     (mod_done),
    .rem_zero (mod_rem_zero)
  );

endmodule

// ===== bench/prcc_checker.sv =====
// Checker for the palette RAM color-cycling block: watches the input, result and
// configuration ports, predicts every result and compares it field by field.
// Depends on prcc_pkg for the item kinds, register indexes and field widths.
module palette_cycling_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic [2:0]  in_tuser,   // op[1:0], palette_sel[2]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // read_colour[14:0], zero[15]
  input  logic [0:0]  out_tuser,  // rotated[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          errors,
  output int          pending,
  output int          results_seen,
  output int          reads_seen,
  output int          rotations_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import prcc_pkg::*;

  typedef struct packed {
    logic [COLOR_W-1:0] colour;
    logic               rotated;
  } cycle_result_t;

  // Shadow copy of both palettes, the frame counter and the cycling setup.
  logic [COLOR_W-1:0] palette_mem [2][PALETTE_ENTRIES_DEF];
  logic [CNT_W-1:0]   frame_count;
  logic [IDX_W-1:0]   cyc_start;
  logic [RCNT_W-1:0]  cyc_count;
  logic [SPD_W-1:0]   cyc_speed;
  logic               cyc_pal;

  cycle_result_t expected_results[$];
  int err_total = 0;
  int result_total = 0;
  int read_total = 0;
  int rot_total = 0;

  // Rotate the configured range of one palette by one place, clipped at the top.
  task automatic shift_range(input logic sel, input logic up, output logic moved);
    int first;
    int last;
    logic [COLOR_W-1:0] keep;
    moved = 1'b0;
    first = int'(cyc_start);
    if (cyc_count < 2) return;
    last = first + int'(cyc_count) - 1;
    if (last > PALETTE_ENTRIES_DEF - 1) last = PALETTE_ENTRIES_DEF - 1;
    if (last <= first) return;
    if (up) begin
      keep = palette_mem[sel][last];
      for (int i = last; i > first; i--) palette_mem[sel][i] = palette_mem[sel][i-1];
      palette_mem[sel][first] = keep;
    end else begin
      keep = palette_mem[sel][first];
      for (int i = first; i < last; i++) palette_mem[sel][i] = palette_mem[sel][i+1];
      palette_mem[sel][last] = keep;
    end
    moved = 1'b1;
  endtask

  // Apply one accepted item to the shadow state and work out its result.
  task automatic predict_item(input op_t op, input logic sel, input logic [7:0] idx,
                              input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, output cycle_result_t res);
    int period;
    logic down;
    logic moved;
    res = '0;
    case (op)
      OP_WRITE: palette_mem[sel][idx] = {b[7:3], g[7:3], r[7:3]};
      OP_READ: res.colour = palette_mem[sel][idx];
      OP_TICK: begin
        frame_count = frame_count + 1'b1;
        down = cyc_speed[SPD_W-1];
        // A negative speed counts its magnitude; -128 gives a period of 128.
        period = down ? (1 << SPD_W) - int'(cyc_speed) : int'(cyc_speed);
        if (period != 0 && (int'(frame_count) % period) == 0) begin
          shift_range(cyc_pal, !down, moved);
          res.rotated = moved;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    cycle_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < PALETTE_ENTRIES_DEF; i++) begin
        palette_mem[0][i] = '0;
        palette_mem[1][i] = '0;
      end
      frame_count = '0;
      cyc_start = '0;
      cyc_count = '0;
      cyc_speed = '0;
      cyc_pal = 1'b0;
      expected_results.delete();
    end else begin
      // Register writes land at the access cycle.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_RANGE_START:    cyc_start = cfg_pwdata[IDX_W-1:0];
          REG_RANGE_COUNT:    cyc_count = cfg_pwdata[RCNT_W-1:0];
          REG_ROTATE_SPEED:   cyc_speed = cfg_pwdata[SPD_W-1:0];
          REG_ROTATE_PALETTE: cyc_pal = cfg_pwdata[0];
          default: ;
        endcase
      end

      // Compare each result transfer with the oldest prediction.
      if (out_tvalid && out_tready) begin
        result_total++;
        if (expected_results.size() == 0) begin
          err_total++;
          $display("%0t ns: result with nothing expected, tdata %h tuser %b",
                   $time, out_tdata, out_tuser);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata !== {1'b0, want.colour}) begin
            err_total++;
            $display("%0t ns: read_colour expected %h, actual %h",
                     $time, {1'b0, want.colour}, out_tdata);
          end
          if (out_tuser[0] !== want.rotated) begin
            err_total++;
            $display("%0t ns: rotated expected %b, actual %b",
                     $time, want.rotated, out_tuser[0]);
          end
        end
      end

      // Predict the result of each input transfer.
      if (in_tvalid && in_tready) begin
        predict_item(op_t'(in_tuser[1:0]), in_tuser[2], in_tdata[7:0], in_tdata[15:8],
                     in_tdata[23:16], in_tdata[31:24], want);
        if (op_t'(in_tuser[1:0]) == OP_READ) read_total++;
        if (want.rotated) rot_total++;
        expected_results.push_back(want);
      end
    end
    errors <= err_total;
    pending <= expected_results.size();
    results_seen <= result_total;
    reads_seen <= read_total;
    rotations_seen <= rot_total;
  end

endmodule

// ===== bench/tb_palette_ram_color_cycling.sv =====
// Top of the palette RAM color-cycling testbench: clock, reset, stimulus and verdict.
// Depends on prcc_pkg, the block palette_ram_color_cycling and palette_cycling_checker.
module tb_palette_ram_color_cycling;
  timeunit 1ns;
  timeprecision 1ps;
  import prcc_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 600;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 103;

  typedef enum int {SINK_OPEN, SINK_BUSY, SINK_CHOKED} sink_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending;
  int results_seen;
  int reads_seen;
  int rotations_seen;

  bit          hold_req = 1'b0;
  int          burst_left = 0;
  logic [15:0] tick_total = '0;
  logic [7:0]  cur_start;
  logic [8:0]  cur_count;
  logic        cur_pal;

  always #5 clk = ~clk;

  palette_ram_color_cycling dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  palette_cycling_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .errors(fail_count), .pending(pending), .results_seen(results_seen),
    .reads_seen(reads_seen), .rotations_seen(rotations_seen)
  );

  // Offer one item and hold it until the transfer happens.
  task automatic send_item(input op_t op, input logic sel, input logic [7:0] idx,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    in_tvalid <= 1'b1;
    in_tdata <= {b, g, r, idx};
    in_tuser <= {sel, op};
    do @(posedge clk); while (!in_tready);
    if (op == OP_TICK) tick_total = tick_total + 1'b1;
  endtask

  // Drop valid and stay quiet for a number of cycles.
  task automatic go_quiet(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Bursts of random length separated by gaps, now and then a long one.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      go_quiet(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8));
      burst_left = $urandom_range(0, 20);
    end
  endtask

  // Stop sending until every predicted result has come back.
  task automatic drain();
    go_quiet(1);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {index, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] start, input logic [8:0] count,
                           input logic [7:0] speed, input logic pal);
    cur_start = start;
    cur_count = count;
    cur_pal = pal;
    write_reg(REG_RANGE_START, {24'd0, start});
    write_reg(REG_RANGE_COUNT, {23'd0, count});
    write_reg(REG_ROTATE_SPEED, {24'd0, speed});
    write_reg(REG_ROTATE_PALETTE, {31'd0, pal});
  endtask

  // Random item, with indexes mostly near the rotating range so shifts show up in reads.
  task automatic random_item();
    int pick;
    int reach;
    op_t op;
    logic sel;
    logic [7:0] idx;
    pick = $urandom_range(0, 99);
    if (pick < 36) op = OP_WRITE;
    else if (pick < 72) op = OP_READ;
    else if (pick < 95) op = OP_TICK;
    else op = OP_NONE;
    sel = ($urandom_range(0, 1) == 0) ? cur_pal : 1'($urandom_range(0, 1));
    reach = (cur_count > 24) ? 25 : int'(cur_count) + 1;
    if ($urandom_range(0, 9) < 6) idx = 8'(int'(cur_start) + $urandom_range(0, reach));
    else idx = 8'($urandom);
    send_item(op, sel, idx, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Result side: stalls on a pattern of its own, and once holds off for a long stretch.
  initial begin : result_sink
    sink_mode_t mode;
    mode = SINK_OPEN;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 49) == 0) mode = sink_mode_t'($urandom_range(0, 2));
      case (mode)
        SINK_OPEN: out_tready <= 1'b1;
        SINK_BUSY: out_tready <= ($urandom_range(0, 3) != 0);
        default:   out_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin : watchdog
    #100ms;
    $display("palette_ram_color_cycling: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] speed;
    logic [8:0] count;
    int k;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: speed zero still counts ticks, colour packing at the extremes,
    // reads of both palettes including an untouched entry, and the unused code.
    send_item(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_WRITE, 1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_WRITE, 1'b1, 8'hFF, 8'h07, 8'h08, 8'hF8);
    send_item(OP_WRITE, 1'b0, 8'hFF, 8'h80, 8'h7F, 8'h55);
    send_item(OP_WRITE, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_READ, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_READ, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_READ, 1'b1, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_item(OP_READ, 1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_READ, 1'b0, 8'h11, 8'h00, 8'h00, 8'h00);
    send_item(OP_NONE, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_TICK, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    // A range running past the last entry is clipped to the top two entries.
    drain();
    configure(8'd254, 9'd256, 8'h01, 1'b0);
    send_item(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_READ, 1'b0, 8'hFE, 8'h00, 8'h00, 8'h00);
    send_item(OP_READ, 1'b0, 8'hFF, 8'h00, 8'h00, 8'h00);

    // A one-entry range never rotates.
    drain();
    configure(8'd254, 9'd1, 8'h01, 1'b0);
    send_item(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);

    // Whole sprite palette rotating down every tick.
    drain();
    configure(8'd0, 9'd256, 8'hFF, 1'b1);
    send_item(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_READ, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_READ, 1'b1, 8'hFF, 8'h00, 8'h00, 8'h00);

    // Walk the frame counter to just short of a multiple of 128 with cycling off,
    // then cross it with speed -128 on a clipped sprite range.
    drain();
    configure(8'd250, 9'd256, 8'h00, 1'b1);
    for (int i = 0; i < 6; i++)
      send_item(OP_WRITE, 1'b1, 8'(250 + i), 8'($urandom), 8'($urandom), 8'($urandom));
    while (tick_total[6:0] != 7'h78)
      send_item(OP_TICK, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom));
    drain();
    configure(8'd250, 9'd256, 8'h80, 1'b1);
    for (int i = 0; i < 12; i++) send_item(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 6; i++) send_item(OP_READ, 1'b1, 8'(250 + i), 8'h00, 8'h00, 8'h00);

    // Random phases, each with its own cycling setup; the first ones hit the extremes.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: configure(8'd0, 9'd0, 8'h7F, 1'b0);
        1: configure(8'd255, 9'd256, 8'h01, 1'b1);
        2: configure(8'($urandom), 9'($urandom_range(2, 12)), 8'h01, 1'b0);
        3: configure(8'($urandom), 9'($urandom_range(3, 20)), 8'hFF, 1'b1);
        4: configure(8'd0, 9'd256, 8'h02, 1'($urandom));
        default: begin
          count = ($urandom_range(0, 9) != 0) ? 9'($urandom_range(0, 24))
                                              : 9'($urandom_range(0, 256));
          k = $urandom_range(1, 3);
          if ($urandom_range(0, 1) == 0) speed = 8'($urandom);
          else speed = ($urandom_range(0, 1) == 0) ? 8'(k) : 8'(-k);
          configure(8'($urandom), count, speed, 1'($urandom));
        end
      endcase

      // Long receiver hold while the sender keeps offering items back to back.
      if (phase == 3) begin
        hold_req = 1'b1;
        for (int i = 0; i < 60; i++) random_item();
        go_quiet(1);
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_item();
        if ($urandom_range(0, 99) == 0) drain();
        else pace();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d results: %0d palette reads and %0d range rotations,",
             results_seen, reads_seen, rotations_seen);
    $display("with all four registers swept and the slowest rotation period crossed.");
    if (fail_count == 0 && pending == 0)
      $display("palette_ram_color_cycling: match");
    else
      $display("palette_ram_color_cycling: mismatch");
    $finish;
  end

endmodule
